FILE: design/iou_trk_pkg.sv
package iou_trk_pkg;

   // field widths
   localparam int COORD_W  = 14;
   localparam int SIZE_W   = 13;
   localparam int AREA_W   = 2 * SIZE_W;
   localparam int UNION_W  = AREA_W + 1;
   localparam int ID_W     = 17;
   localparam int SCORE_W  = 10;
   localparam int THR_W    = 10;
   localparam int BOX_W    = 2 * COORD_W + 2 * SIZE_W;
   localparam int ENTRY_W  = BOX_W + ID_W;
   localparam int REQ_W    = 56;
   localparam int RSP_W    = 32;

   // divider working width: numerator is area times the score scale
   localparam int DIV_W    = AREA_W + SCORE_W + 1;

   localparam logic [SCORE_W-1:0] SCORE_SCALE = 10'd1000;
   localparam logic [THR_W-1:0]   THR_RESET   = 10'd800;

   // parameter defaults
   localparam int MAX_TRACKS_DEF = 64;
   localparam int ID_MODULUS_DEF = 100000;

   // controller to datapath commands
   typedef struct packed {
      logic load;       // latch accepted box, clear best
      logic div_init;   // load numerator and shifted union
      logic div_step;   // one quotient bit
      logic compare;    // fold score into best
      logic finish;     // decide identity, load result register
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic last;       // latched frame end of the current box
   } status_type;

endpackage

FILE: design/iou_greedy_box_tracker.sv
// Channel  Direction  Handshake          Contents
// req      in         tvalid/tready      tdata: box_x, box_y, box_w, box_h; tlast: frame_end
// rsp      out        tvalid/tready      tdata: track_id, best_score; tuser: is_new;
//                                        tlast: last_in_frame
// csr      in         csr_valid/ready    csr_data: match_threshold
//
// A box is compared with each stored box of the previous frame:
// each stored box is read, scored in three product stages and a ten-step
// restoring divider, then compared.
// Reset is synchronous and active high; no clearing pass is needed.
// A new box is taken while the last result waits; a box that finishes
// before that result is taken holds until the result register frees.
module iou_greedy_box_tracker #(
   parameter int MAX_TRACKS = iou_trk_pkg::MAX_TRACKS_DEF,
   parameter int ID_MODULUS = iou_trk_pkg::ID_MODULUS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // box_x[13:0], box_y[27:14], box_w[40:28], box_h[53:41], zero fill
   input  logic [iou_trk_pkg::REQ_W-1:0] req_tdata,
   input  logic                          req_tlast,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // track_id[16:0], best_score[26:17], zero fill
   output logic [iou_trk_pkg::RSP_W-1:0] rsp_tdata,
   // is_new[0]
   output logic                          rsp_tuser,
   output logic                          rsp_tlast,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [iou_trk_pkg::THR_W-1:0] csr_data
);

   localparam int IDX_W = MAX_TRACKS > 1 ? $clog2(MAX_TRACKS) : 1;
   localparam int EW    = iou_trk_pkg::ENTRY_W;

   iou_trk_pkg::cmd_type    cmd;
   iou_trk_pkg::status_type status;

   logic             bank_sel, rd_en, wr_en;
   logic [IDX_W-1:0] rd_addr, wr_addr;
   logic [EW-1:0]    rd_data0, rd_data1, rd_entry, wr_entry;
   logic [iou_trk_pkg::ID_W-1:0]    track_id;
   logic [iou_trk_pkg::SCORE_W-1:0] best_score;

   assign csr_ready = 1'b1;

   iou_trk_ctrl #(.MAX_TRACKS(MAX_TRACKS)) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status),
      .bank_sel   (bank_sel),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr)
   );

   iou_trk_dp #(.ID_MODULUS(ID_MODULUS)) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_tdata      (req_tdata),
      .req_tlast      (req_tlast),
      .csr_write      (csr_valid),
      .csr_data       (csr_data),
      .rd_entry       (rd_entry),
      .wr_entry       (wr_entry),
      .rsp_track_id   (track_id),
      .rsp_is_new     (rsp_tuser),
      .rsp_best_score (best_score),
      .rsp_last       (rsp_tlast)
   );

   // ping-pong banks: bank_sel holds the previous frame
   iou_trk_ram #(.WIDTH(EW), .DEPTH(MAX_TRACKS)) u_bank0 (
      .clock   (clock),
      .wr_en   (wr_en && bank_sel),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_en   (rd_en && !bank_sel),
      .rd_addr (rd_addr),
      .rd_data (rd_data0)
   );

   iou_trk_ram #(.WIDTH(EW), .DEPTH(MAX_TRACKS)) u_bank1 (
      .clock   (clock),
      .wr_en   (wr_en && !bank_sel),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_en   (rd_en && bank_sel),
      .rd_addr (rd_addr),
      .rd_data (rd_data1)
   );

   assign rd_entry  = bank_sel ? rd_data1 : rd_data0;
   assign rsp_tdata = {5'b0, best_score, track_id};

endmodule

FILE: design/iou_trk_ram.sv
module iou_trk_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read, held while not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/iou_trk_dp.sv
module iou_trk_dp #(
   parameter int ID_MODULUS = iou_trk_pkg::ID_MODULUS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  iou_trk_pkg::cmd_type                  cmd,
   output iou_trk_pkg::status_type               status,
   input  logic [iou_trk_pkg::REQ_W-1:0]         req_tdata,
   input  logic                                  req_tlast,
   input  logic                                  csr_write,
   input  logic [iou_trk_pkg::THR_W-1:0]         csr_data,
   input  logic [iou_trk_pkg::ENTRY_W-1:0]       rd_entry,
   output logic [iou_trk_pkg::ENTRY_W-1:0]       wr_entry,
   output logic [iou_trk_pkg::ID_W-1:0]          rsp_track_id,
   output logic                                  rsp_is_new,
   output logic [iou_trk_pkg::SCORE_W-1:0]       rsp_best_score,
   output logic                                  rsp_last
);

   localparam int CW = iou_trk_pkg::COORD_W;
   localparam int SW = iou_trk_pkg::SIZE_W;
   localparam int AW = iou_trk_pkg::AREA_W;
   localparam int UW = iou_trk_pkg::UNION_W;
   localparam int DW = iou_trk_pkg::DIV_W;
   localparam int QW = iou_trk_pkg::SCORE_W;
   localparam int IW = iou_trk_pkg::ID_W;

   // current box
   logic signed [CW-1:0] ax_ff, ay_ff;
   logic [SW-1:0]        aw_ff, ah_ff;
   logic [AW-1:0]        area_a_ff;
   logic                 last_ff;

   // stored box fields from the read port
   logic signed [CW-1:0] bx, by;
   logic [SW-1:0]        bw, bh;
   logic [IW-1:0]        bid;

   logic signed [CW:0]   ra, rb, ba, bb, x_lo, x_hi, y_lo, y_hi;
   logic signed [CW+1:0] iw_s, ih_s;

   logic [SW-1:0]        iw_ff, ih_ff;
   logic                 ok_ff;
   logic [AW-1:0]        area_b_ff;
   logic [AW-1:0]        inter_ff;

   logic [DW-1:0]        rem_ff, dsh_ff;
   logic [QW-1:0]        q_ff;
   logic [UW-1:0]        uni;
   logic [QW-1:0]        score;

   logic [QW-1:0]        best_ff;
   logic [IW-1:0]        best_id_ff;
   logic [iou_trk_pkg::THR_W-1:0] thr_ff;
   logic [IW-1:0]        fresh_ff;
   logic                 inherit;
   logic [IW-1:0]        new_id;

   assign bx  = rd_entry[CW-1:0];
   assign by  = rd_entry[2*CW-1:CW];
   assign bw  = rd_entry[2*CW+SW-1:2*CW];
   assign bh  = rd_entry[iou_trk_pkg::BOX_W-1:2*CW+SW];
   assign bid = rd_entry[iou_trk_pkg::ENTRY_W-1:iou_trk_pkg::BOX_W];

   // edges of both boxes and overlap extents
   always_comb begin
      ra   = (CW+1)'(ax_ff) + $signed({2'b00, aw_ff});
      rb   = (CW+1)'(bx) + $signed({2'b00, bw});
      ba   = (CW+1)'(ay_ff) + $signed({2'b00, ah_ff});
      bb   = (CW+1)'(by) + $signed({2'b00, bh});
      x_hi = (ra < rb) ? ra : rb;
      x_lo = (ax_ff > bx) ? (CW+1)'(ax_ff) : (CW+1)'(bx);
      y_hi = (ba < bb) ? ba : bb;
      y_lo = (ay_ff > by) ? (CW+1)'(ay_ff) : (CW+1)'(by);
      iw_s = (CW+2)'(x_hi) - (CW+2)'(x_lo);
      ih_s = (CW+2)'(y_hi) - (CW+2)'(y_lo);
   end

   assign uni   = UW'(area_a_ff) + UW'(area_b_ff) - UW'(inter_ff);
   assign score = ok_ff ? q_ff : '0;

   // latch the accepted box
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         ax_ff     <= req_tdata[CW-1:0];
         ay_ff     <= req_tdata[2*CW-1:CW];
         aw_ff     <= req_tdata[2*CW+SW-1:2*CW];
         ah_ff     <= req_tdata[iou_trk_pkg::BOX_W-1:2*CW+SW];
         area_a_ff <= req_tdata[2*CW+SW-1:2*CW] * req_tdata[iou_trk_pkg::BOX_W-1:2*CW+SW];
         last_ff   <= req_tlast;
      end
   end

   // overlap and product stages
   always_ff @(posedge clock) begin
      ok_ff     <= (iw_s > 0) && (ih_s > 0);
      iw_ff     <= iw_s[SW-1:0];
      ih_ff     <= ih_s[SW-1:0];
      area_b_ff <= bw * bh;
      inter_ff  <= iw_ff * ih_ff;
   end

   // restoring divider, one quotient bit per step
   always_ff @(posedge clock) begin
      if (cmd.div_init) begin
         rem_ff <= DW'(inter_ff) * DW'(iou_trk_pkg::SCORE_SCALE);
         dsh_ff <= DW'(uni) << (QW - 1);
         q_ff   <= '0;
      end else if (cmd.div_step) begin
         if (rem_ff >= dsh_ff) begin
            rem_ff <= rem_ff - dsh_ff;
            q_ff   <= {q_ff[QW-2:0], 1'b1};
         end else begin
            q_ff   <= {q_ff[QW-2:0], 1'b0};
         end
         dsh_ff <= dsh_ff >> 1;
      end
   end

   // keep first strictly highest score
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         best_ff <= '0;
      end else if (cmd.compare && (score > best_ff)) begin
         best_ff    <= score;
         best_id_ff <= bid;
      end
   end

   assign inherit = (best_ff != '0) && (best_ff > thr_ff);
   assign new_id  = inherit ? best_id_ff : fresh_ff;

   // threshold register and fresh identity counter
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff   <= iou_trk_pkg::THR_RESET;
         fresh_ff <= '0;
      end else begin
         if (csr_write) begin
            thr_ff <= csr_data;
         end
         if (cmd.finish && !inherit) begin
            fresh_ff <= (fresh_ff == IW'(ID_MODULUS - 1)) ? '0 : fresh_ff + 1'b1;
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_track_id   <= new_id;
         rsp_is_new     <= !inherit;
         rsp_best_score <= best_ff;
         rsp_last       <= last_ff;
      end
   end

   assign wr_entry    = {new_id, ah_ff, aw_ff, ay_ff, ax_ff};
   assign status.last = last_ff;

endmodule

FILE: design/iou_trk_ctrl.sv
module iou_trk_ctrl #(
   parameter int MAX_TRACKS = iou_trk_pkg::MAX_TRACKS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output iou_trk_pkg::cmd_type             cmd,
   input  iou_trk_pkg::status_type          status,
   output logic                             bank_sel,
   output logic                             rd_en,
   output logic [(MAX_TRACKS > 1 ? $clog2(MAX_TRACKS) : 1)-1:0] rd_addr,
   output logic                             wr_en,
   output logic [(MAX_TRACKS > 1 ? $clog2(MAX_TRACKS) : 1)-1:0] wr_addr
);

   localparam int IDX_W = MAX_TRACKS > 1 ? $clog2(MAX_TRACKS) : 1;
   localparam int CNT_W = $clog2(MAX_TRACKS + 1);
   localparam int DC_W  = $clog2(iou_trk_pkg::SCORE_W);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_ISSUE = 3'd1;
   localparam logic [2:0] S_MUL1  = 3'd2;
   localparam logic [2:0] S_MUL2  = 3'd3;
   localparam logic [2:0] S_MUL3  = 3'd4;
   localparam logic [2:0] S_DIV   = 3'd5;
   localparam logic [2:0] S_CMP   = 3'd6;
   localparam logic [2:0] S_FIN   = 3'd7;

   logic [2:0]       state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [DC_W-1:0]  dcnt_ff, dcnt_in;
   logic [CNT_W-1:0] prev_cnt_ff, prev_cnt_in;
   logic [CNT_W-1:0] cur_cnt_ff, cur_cnt_in;
   logic             sel_ff, sel_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             accept, slot_free, room;
   logic [CNT_W-1:0] cur_cnt_inc;

   assign accept      = req_tvalid && req_tready;
   assign slot_free   = !rsp_valid_ff || rsp_tready;
   assign room        = cur_cnt_ff < CNT_W'(MAX_TRACKS);
   assign cur_cnt_inc = room ? cur_cnt_ff + 1'b1 : cur_cnt_ff;

   // sequence one box over all stored boxes
   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      dcnt_in      = dcnt_ff;
      prev_cnt_in  = prev_cnt_ff;
      cur_cnt_in   = cur_cnt_ff;
      sel_in       = sel_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = '0;
      rd_en        = 1'b0;
      wr_en        = 1'b0;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.load = 1'b1;
               idx_in   = '0;
               state_in = (prev_cnt_ff == '0) ? S_FIN : S_ISSUE;
            end
         end
         S_ISSUE: begin
            rd_en    = 1'b1;
            state_in = S_MUL1;
         end
         S_MUL1: state_in = S_MUL2;
         S_MUL2: state_in = S_MUL3;
         S_MUL3: begin
            cmd.div_init = 1'b1;
            dcnt_in      = '0;
            state_in     = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            dcnt_in      = dcnt_ff + 1'b1;
            if (dcnt_ff == DC_W'(iou_trk_pkg::SCORE_W - 1)) begin
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            cmd.compare = 1'b1;
            if (CNT_W'(idx_ff) + CNT_W'(1) == prev_cnt_ff) begin
               state_in = S_FIN;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_ISSUE;
            end
         end
         S_FIN: begin
            if (slot_free) begin
               cmd.finish   = 1'b1;
               wr_en        = room;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
               if (status.last) begin
                  prev_cnt_in = cur_cnt_inc;
                  cur_cnt_in  = '0;
                  sel_in      = !sel_ff;
               end else begin
                  cur_cnt_in  = cur_cnt_inc;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         prev_cnt_ff  <= '0;
         cur_cnt_ff   <= '0;
         sel_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         prev_cnt_ff  <= prev_cnt_in;
         cur_cnt_ff   <= cur_cnt_in;
         sel_ff       <= sel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff  <= idx_in;
      dcnt_ff <= dcnt_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign bank_sel   = sel_ff;
   assign rd_addr    = idx_ff;
   assign wr_addr    = cur_cnt_ff[IDX_W-1:0];

endmodule

FILE: design/iou_trk_chk.sv
module iou_trk_chk #(
   parameter int ID_MODULUS = iou_trk_pkg::ID_MODULUS_DEF
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_tvalid,
   input logic                          rsp_tready,
   input logic [iou_trk_pkg::RSP_W-1:0] rsp_tdata,
   input logic                          rsp_tuser,
   input logic                          rsp_tlast
);

   // hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("rsp changed while stalled");

   // score never above full overlap
   a_score_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[26:17] <= 10'd1000)
      else $error("best_score out of range");

   // an inherited identity needs some overlap
   a_inherit_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[26:17] != 10'd0)
      else $error("inherited identity without overlap");

   // identities stay below the wrap point
   a_id_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> 32'(rsp_tdata[16:0]) < ID_MODULUS)
      else $error("track_id out of range");

endmodule

bind iou_greedy_box_tracker iou_trk_chk #(.ID_MODULUS(ID_MODULUS)) u_chk (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
